FILE: rtl/trne_pkg.sv
// Shared types and constants of the tree routing node engine.
package trne_pkg;

  localparam logic [15:0] FREE_SLOT  = 16'hffff;
  localparam logic [15:0] BCAST_ADDR = 16'hffff;
  localparam logic [7:0]  HOPS_NONE  = 8'hff;
  localparam logic [7:0]  HOPS_SINK  = 8'h00;

  localparam logic [15:0] MY_ADDR_RST = 16'd0;
  localparam logic [15:0] BPER_RST    = 16'd3000;
  localparam logic [15:0] TPER_RST    = 16'd10000;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_ADDR = 2'd0,
    CFG_IS_SINK = 2'd1,
    CFG_BPER    = 2'd2,
    CFG_TPER    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_BEACON = 3'd1,
    REQ_UP     = 3'd2,
    REQ_DOWN   = 3'd3,
    REQ_SEND   = 3'd4
  } req_kind_e;

  typedef enum logic [1:0] {
    ACT_BCAST   = 2'd0,
    ACT_UCAST   = 2'd1,
    ACT_DELIVER = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    FRM_BEACON = 2'd0,
    FRM_UP     = 2'd1,
    FRM_DOWN   = 2'd2
  } frame_e;

  typedef enum logic [1:0] {
    MODE_UNCONN = 2'd0,
    MODE_CONN   = 2'd1,
    MODE_GW     = 2'd2
  } mode_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] peer;
    logic [7:0]  metric;
    logic [7:0]  rhops;
    logic [15:0] src;
    logic [15:0] key;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] dest;
    frame_e      frame;
    logic [7:0]  hops;
    logic [15:0] source;
    mode_e       state;
  } result_t;

endpackage

FILE: rtl/trne_front.sv
// Front end: accepts request items, drops unused request types and queues the rest.
module trne_front import trne_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  output logic        q_vld_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  localparam int unsigned QDepth = 2;

  item_t       q_mem [QDepth];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  fill_q, fill_d;
  logic        legal;
  logic        push;
  item_t       item;

  always_comb begin
    legal = 1'b0;
    item.kind = REQ_TICK;
    case (s_axis_tuser)
      REQ_TICK:   begin legal = 1'b1; item.kind = REQ_TICK;   end
      REQ_BEACON: begin legal = 1'b1; item.kind = REQ_BEACON; end
      REQ_UP:     begin legal = 1'b1; item.kind = REQ_UP;     end
      REQ_DOWN:   begin legal = 1'b1; item.kind = REQ_DOWN;   end
      REQ_SEND:   begin legal = 1'b1; item.kind = REQ_SEND;   end
      default:    legal = 1'b0;
    endcase
    item.peer   = s_axis_tdata[15:0];
    item.metric = s_axis_tdata[23:16];
    item.rhops  = s_axis_tdata[31:24];
    item.src    = s_axis_tdata[47:32];
    item.key    = (s_axis_tuser == REQ_BEACON) ? s_axis_tdata[15:0] : s_axis_tdata[47:32];
  end

  assign s_axis_tready = (fill_q != 2'(QDepth));
  assign push          = s_axis_tvalid && s_axis_tready && legal;
  assign q_vld_o       = (fill_q != 2'd0);
  assign q_item_o      = q_mem[rd_q];

  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = q_pop_i ? ~rd_q : rd_q;
    fill_d = fill_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_vld_o)
    else $error("Queue popped while empty.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'(QDepth))
    else $error("Queue fill count out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      push && !q_pop_i |=> fill_q == $past(fill_q) + 2'd1)
    else $error("Queue fill count lost a push.");

endmodule

FILE: rtl/trne_back.sv
// Back end: child table scan, node state, decisions and the result register.
module trne_back import trne_pkg::*; #(
  parameter int unsigned CHILD_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 q_vld_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output logic                 res_vld_o,
  output result_t              res_o,
  input  logic                 res_rdy_i
);

  localparam int unsigned CntW = $clog2(CHILD_SLOTS + 1);
  localparam int unsigned IdxW = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } bk_state_e;

  logic [15:0] child_mem [CHILD_SLOTS];
  logic [15:0] rdata_q;

  bk_state_e   st_q, st_d;
  item_t       cur_q, cur_d;
  mode_e       mode_q, mode_d;
  logic [15:0] parent_q, parent_d;
  logic [7:0]  hops_q, hops_d;
  logic [7:0]  pmetric_q, pmetric_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic        found_q, found_d;
  logic        cmp_vld_q, cmp_vld_d;
  logic [15:0] myaddr_q, myaddr_d;
  logic [15:0] bper_q, bper_d;
  logic [15:0] tper_q, tper_d;
  logic        out_vld_q, out_vld_d;
  result_t     out_q, out_d;

  logic        issue;
  logic        hit;
  logic        known;
  logic        table_free;
  logic [15:0] el_inc;
  logic        commit;
  logic        child_we;

  mode_e       ex_mode;
  logic [15:0] ex_parent;
  logic [7:0]  ex_hops;
  logic [7:0]  ex_pmetric;
  logic [15:0] ex_elapsed;
  logic        ex_clr;
  logic        ex_add;
  logic        ex_vld;
  result_t     ex_res;

  assign table_free = (cnt_q < CntW'(CHILD_SLOTS));
  assign issue      = (st_q == ST_SCAN) && (idx_q < cnt_q);
  assign hit        = cmp_vld_q && (rdata_q == cur_q.key);
  assign known      = found_q || ((cur_q.key == FREE_SLOT) && table_free);
  assign el_inc     = (elapsed_q == 16'hffff) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    ex_mode    = mode_q;
    ex_parent  = parent_q;
    ex_hops    = hops_q;
    ex_pmetric = pmetric_q;
    ex_elapsed = elapsed_q;
    ex_clr     = 1'b0;
    ex_add     = 1'b0;
    ex_vld     = 1'b0;
    ex_res     = '0;
    case (cur_q.kind)
      REQ_TICK: begin
        ex_elapsed = el_inc;
        if (mode_q == MODE_GW) begin
          if (el_inc > bper_q) begin
            ex_elapsed  = 16'd0;
            ex_vld      = 1'b1;
            ex_res.dest = BCAST_ADDR;
            ex_res.hops = hops_q;
          end
        end else if (el_inc > tper_q) begin
          ex_mode   = MODE_UNCONN;
          ex_parent = 16'd0;
          ex_hops   = HOPS_NONE;
          ex_clr    = 1'b1;
        end
      end
      REQ_BEACON: begin
        if (!known && (mode_q != MODE_GW)) begin
          if ((hops_q == HOPS_NONE) || (pmetric_q > cur_q.metric)) begin
            ex_hops     = (cur_q.rhops == HOPS_NONE) ? HOPS_NONE : cur_q.rhops + 8'd1;
            ex_parent   = cur_q.peer;
            ex_mode     = MODE_CONN;
            ex_elapsed  = 16'd0;
            ex_pmetric  = cur_q.metric;
            ex_vld      = 1'b1;
            ex_res.dest = BCAST_ADDR;
            ex_res.hops = ex_hops;
          end else if ((mode_q == MODE_CONN) && (parent_q == cur_q.peer)) begin
            ex_elapsed  = 16'd0;
            ex_vld      = 1'b1;
            ex_res.dest = BCAST_ADDR;
            ex_res.hops = hops_q;
          end
        end
      end
      REQ_UP: begin
        if (mode_q == MODE_GW) begin
          ex_vld        = 1'b1;
          ex_res.action = ACT_DELIVER;
          ex_res.dest   = myaddr_q;
          ex_res.source = cur_q.src;
        end else if (parent_q != 16'd0) begin
          ex_add        = !known && table_free;
          ex_vld        = 1'b1;
          ex_res.action = ACT_UCAST;
          ex_res.dest   = parent_q;
          ex_res.frame  = FRM_UP;
          ex_res.source = cur_q.src;
        end
      end
      REQ_DOWN: begin
        if (cur_q.src == myaddr_q) begin
          ex_vld        = 1'b1;
          ex_res.action = ACT_DELIVER;
          ex_res.dest   = myaddr_q;
          ex_res.source = cur_q.src;
        end else if ((mode_q != MODE_GW) && (cur_q.peer == parent_q) && known) begin
          ex_vld        = 1'b1;
          ex_res.dest   = BCAST_ADDR;
          ex_res.frame  = FRM_DOWN;
          ex_res.source = cur_q.src;
        end
      end
      REQ_SEND: begin
        ex_vld = 1'b1;
        if (mode_q == MODE_GW) begin
          ex_res.dest   = BCAST_ADDR;
          ex_res.frame  = FRM_DOWN;
          ex_res.source = cur_q.peer;
        end else begin
          ex_res.action = ACT_UCAST;
          ex_res.dest   = parent_q;
          ex_res.frame  = FRM_UP;
          ex_res.source = myaddr_q;
        end
      end
      default: ex_vld = 1'b0;
    endcase
    ex_res.state = ex_mode;
  end

  assign commit = (st_q == ST_EXEC) && (!ex_vld || !out_vld_q || res_rdy_i);

  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    mode_d    = mode_q;
    parent_d  = parent_q;
    hops_d    = hops_q;
    pmetric_d = pmetric_q;
    elapsed_d = elapsed_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    found_d   = found_q;
    cmp_vld_d = 1'b0;
    myaddr_d  = myaddr_q;
    bper_d    = bper_q;
    tper_d    = tper_q;
    out_vld_d = out_vld_q && !res_rdy_i;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    child_we  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          found_d = 1'b0;
          idx_d   = '0;
          st_d    = (q_item_i.kind inside {REQ_BEACON, REQ_UP, REQ_DOWN}) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = issue;
        found_d   = found_q || hit;
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end else begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          mode_d    = ex_mode;
          parent_d  = ex_parent;
          hops_d    = ex_hops;
          pmetric_d = ex_pmetric;
          elapsed_d = ex_elapsed;
          child_we  = ex_add;
          if (ex_clr) begin
            cnt_d = '0;
          end else if (ex_add) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (ex_vld) begin
            out_vld_d = 1'b1;
            out_d     = ex_res;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MY_ADDR: myaddr_d = cfg_data_i;
        CFG_IS_SINK: begin
          mode_d = cfg_data_i[0] ? MODE_GW : MODE_UNCONN;
          hops_d = cfg_data_i[0] ? HOPS_SINK : HOPS_NONE;
        end
        CFG_BPER:    bper_d = cfg_data_i;
        CFG_TPER:    tper_d = cfg_data_i;
        default:     myaddr_d = myaddr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[cnt_q[IdxW-1:0]] <= cur_q.src;
    end
    rdata_q <= child_mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      mode_q    <= MODE_UNCONN;
      parent_q  <= 16'd0;
      hops_q    <= HOPS_NONE;
      pmetric_q <= 8'd0;
      elapsed_q <= 16'd0;
      cnt_q     <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      myaddr_q  <= MY_ADDR_RST;
      bper_q    <= BPER_RST;
      tper_q    <= TPER_RST;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      mode_q    <= mode_d;
      parent_q  <= parent_d;
      hops_q    <= hops_d;
      pmetric_q <= pmetric_d;
      elapsed_q <= elapsed_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      cmp_vld_q <= cmp_vld_d;
      myaddr_q  <= myaddr_d;
      bper_q    <= bper_d;
      tper_q    <= tper_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign res_vld_o = out_vld_q;
  assign res_o     = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(CHILD_SLOTS))
    else $error("Child count exceeds the table size.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) mode_q == MODE_GW |-> hops_q == HOPS_SINK)
    else $error("Gateway with a non-zero hop count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      mode_q == MODE_UNCONN |-> hops_q == HOPS_NONE)
    else $error("Unconnected node with a finite hop count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmp_vld_q |-> st_q == ST_SCAN)
    else $error("Table compare outside the scan.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |=> st_q != ST_IDLE)
    else $error("Popped item was not taken up.");

endmodule

FILE: rtl/tree_routing_node_engine.sv
// Top level of the tree routing node engine: front end, back end and port packing.
//
// Request items enter on the s_axis channel: tuser carries the request type, tdata the
// peer address, link metric, hop count and source address. Request types five to seven
// are dropped at the front end. Actions leave on the m_axis channel, at most one per item.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i, and
// should only be written while the engine is idle.
// A two-entry queue separates the front end from the back end, so items are accepted
// while the back end works or while a result waits in the output register.
// Ticks and local sends go from idle straight to the decision state in the back end. Beacons
// and routing headers first scan the child table one entry per cycle through its single read
// port; the result appears in the output register in the cycle after the decision.
// When the receiver stalls, the result is held in the output register, the back end waits
// before its next decision that yields an action, and the queue fills until tready falls.
// Reset returns the node to unconnected with an empty child table, the default
// periods and address zero; no clearing pass is needed.
module tree_routing_node_engine import trne_pkg::*; #(
  parameter int unsigned CHILD_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // peer_addr, link_metric, hop_count, source_addr
  input  logic [47:0]          s_axis_tdata,
  // req_type
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // dest_addr, out_hops, out_source, node_state, zero fill
  output logic [47:0]          m_axis_tdata,
  // action, frame_kind
  output logic [3:0]           m_axis_tuser
);

  logic    q_vld;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  trne_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_vld_o       (q_vld),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  trne_back #(
    .CHILD_SLOTS (CHILD_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_vld_i    (q_vld),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_vld_o  (m_axis_tvalid),
    .res_o      (res),
    .res_rdy_i  (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.state, res.source, res.hops, res.dest};
  assign m_axis_tuser = {res.frame, res.action};

endmodule

FILE: tb/trne_checker.sv
// Checker of the tree routing node engine: predicts every action from the accepted items and compares.
module trne_checker import trne_pkg::*; #(
  parameter int unsigned CHILD_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // peer_addr, link_metric, hop_count, source_addr
  input  logic [47:0]          s_axis_tdata,
  // req_type
  input  logic [2:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // dest_addr, out_hops, out_source, node_state, zero fill
  input  logic [47:0]          m_axis_tdata,
  // action, frame_kind
  input  logic [3:0]           m_axis_tuser,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] my_addr;
  logic        sink;
  logic [15:0] beacon_per;
  logic [15:0] timeout_per;

  mode_e       node_mode;
  logic [15:0] parent_addr;
  logic [7:0]  node_hops;
  logic [7:0]  parent_lq;
  logic [15:0] tick_count;
  logic [15:0] children [CHILD_SLOTS];

  result_t     action_q [$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic logic child_present(input logic [15:0] addr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CHILD_SLOTS; i++) begin
      if (children[i] == addr) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic clear_children();
    for (int i = 0; i < CHILD_SLOTS; i++) children[i] = FREE_SLOT;
  endtask

  task automatic child_insert(input logic [15:0] addr);
    logic done;
    done = 1'b0;
    if (!child_present(addr)) begin
      for (int i = 0; i < CHILD_SLOTS; i++) begin
        if (!done && children[i] == FREE_SLOT) begin
          children[i] = addr;
          done = 1'b1;
        end
      end
    end
  endtask

  task automatic apply_sink();
    if (sink) begin
      node_mode = MODE_GW;
      node_hops = HOPS_SINK;
    end else begin
      node_mode = MODE_UNCONN;
      node_hops = HOPS_NONE;
    end
  endtask

  task automatic reset_node();
    my_addr     = MY_ADDR_RST;
    sink        = 1'b0;
    beacon_per  = BPER_RST;
    timeout_per = TPER_RST;
    parent_addr = 16'h0000;
    parent_lq   = 8'h00;
    tick_count  = 16'h0000;
    clear_children();
    apply_sink();
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (cfg_idx_e'(idx))
      CFG_MY_ADDR: my_addr = val;
      CFG_IS_SINK: begin
        sink = val[0];
        apply_sink();
      end
      CFG_BPER:    beacon_per = val;
      CFG_TPER:    timeout_per = val;
      default: ;
    endcase
  endtask

  task automatic push_action(input action_e act, input logic [15:0] dest, input frame_e frm,
                             input logic [7:0] hops, input logic [15:0] source);
    result_t r;
    r.action = act;
    r.dest   = dest;
    r.frame  = frm;
    r.hops   = hops;
    r.source = source;
    r.state  = node_mode;
    action_q.push_back(r);
  endtask

  task automatic predict_action(input logic [2:0] kind, input logic [47:0] data);
    logic [15:0] peer;
    logic [7:0]  lq;
    logic [7:0]  rhops;
    logic [15:0] src;
    peer  = data[15:0];
    lq    = data[23:16];
    rhops = data[31:24];
    src   = data[47:32];
    case (req_kind_e'(kind))
      REQ_TICK: begin
        if (tick_count != 16'hffff) tick_count = tick_count + 16'd1;
        if (node_mode == MODE_GW) begin
          if (tick_count > beacon_per) begin
            tick_count = 16'h0000;
            push_action(ACT_BCAST, BCAST_ADDR, FRM_BEACON, node_hops, 16'h0000);
          end
        end else if (tick_count > timeout_per) begin
          node_mode   = MODE_UNCONN;
          parent_addr = 16'h0000;
          node_hops   = HOPS_NONE;
          clear_children();
        end
      end
      REQ_BEACON: begin
        if (!child_present(peer) && node_mode != MODE_GW) begin
          if (node_hops == HOPS_NONE || parent_lq > lq) begin
            node_hops   = (rhops == HOPS_NONE) ? HOPS_NONE : rhops + 8'd1;
            parent_addr = peer;
            node_mode   = MODE_CONN;
            tick_count  = 16'h0000;
            parent_lq   = lq;
            push_action(ACT_BCAST, BCAST_ADDR, FRM_BEACON, node_hops, 16'h0000);
          end else if (node_mode == MODE_CONN && parent_addr == peer) begin
            tick_count = 16'h0000;
            push_action(ACT_BCAST, BCAST_ADDR, FRM_BEACON, node_hops, 16'h0000);
          end
        end
      end
      REQ_UP: begin
        if (node_mode == MODE_GW) begin
          push_action(ACT_DELIVER, my_addr, FRM_BEACON, 8'h00, src);
        end else if (parent_addr != 16'h0000) begin
          child_insert(src);
          push_action(ACT_UCAST, parent_addr, FRM_UP, 8'h00, src);
        end
      end
      REQ_DOWN: begin
        if (src == my_addr) begin
          push_action(ACT_DELIVER, my_addr, FRM_BEACON, 8'h00, src);
        end else if (node_mode != MODE_GW && peer == parent_addr && child_present(src)) begin
          push_action(ACT_BCAST, BCAST_ADDR, FRM_DOWN, 8'h00, src);
        end
      end
      REQ_SEND: begin
        if (node_mode == MODE_GW) begin
          push_action(ACT_BCAST, BCAST_ADDR, FRM_DOWN, 8'h00, peer);
        end else begin
          push_action(ACT_UCAST, parent_addr, FRM_UP, 8'h00, my_addr);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_action(input logic [47:0] data, input logic [3:0] user);
    result_t seen;
    result_t want;
    seen.action = action_e'(user[1:0]);
    seen.frame  = frame_e'(user[3:2]);
    seen.dest   = data[15:0];
    seen.hops   = data[23:16];
    seen.source = data[39:24];
    seen.state  = mode_e'(data[41:40]);
    if (action_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t unexpected action: act %0d dest %h frame %0d hops %h src %h state %0d",
                 $realtime, seen.action, seen.dest, seen.frame, seen.hops, seen.source,
                 seen.state);
    end else begin
      want = action_q.pop_front();
      if (seen.action !== want.action || seen.dest !== want.dest ||
          seen.frame !== want.frame || seen.hops !== want.hops ||
          seen.source !== want.source || seen.state !== want.state) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("%0t mismatch: expected act %0d dest %h frame %0d hops %h src %h state %0d",
                   $realtime, want.action, want.dest, want.frame, want.hops, want.source,
                   want.state);
          $display("%0t          actual   act %0d dest %h frame %0d hops %h src %h state %0d",
                   $realtime, seen.action, seen.dest, seen.frame, seen.hops, seen.source,
                   seen.state);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_node();
      action_q.delete();
    end else begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) predict_action(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_action(m_axis_tdata, m_axis_tuser);
    end
    pending_o = action_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top of the tree routing node engine: clock, reset, request stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trne_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0]          cfg_data = 16'h0000;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [47:0]          s_data = 48'h0;
  logic [2:0]           s_user = 3'd0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [47:0]          m_data;
  logic [3:0]           m_user;

  int          fails;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic        no_gaps = 1'b0;
  int          regime = 0;
  int          regime_left = 0;
  int          stall_left = 0;
  logic [15:0] addr_pool [10];
  logic [15:0] last_peer = 16'h0000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tree_routing_node_engine #(.CHILD_SLOTS(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  trne_checker #(.CHILD_SLOTS(SLOTS)) action_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (regime_left == 0) begin
      regime = $urandom_range(0, 2);
      regime_left = $urandom_range(50, 300);
    end else begin
      regime_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      case (regime)
        0: stall_left = 0;
        1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        default: stall_left = $urandom_range(0, 12);
      endcase
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
  endtask

  task automatic program_node(input logic [15:0] addr, input logic sink,
                              input logic [15:0] bper, input logic [15:0] tper);
    write_reg(CFG_MY_ADDR, addr);
    write_reg(CFG_IS_SINK, {15'h0, sink});
    write_reg(CFG_BPER, bper);
    write_reg(CFG_TPER, tper);
    cfg_we <= 1'b0;
  endtask

  task automatic settle(input int extra);
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic drive_req(input logic [2:0] kind, input logic [15:0] peer, input logic [7:0] lq,
                           input logic [7:0] rhops, input logic [15:0] src);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {src, rhops, lq, peer};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, 9)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_hops();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'hff;
    if (r < 20) return 8'hfe;
    if (r < 25) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_req();
    int          r;
    logic [15:0] peer;
    logic [15:0] src;
    logic [7:0]  lq;
    logic [7:0]  rh;
    r    = $urandom_range(0, 99);
    peer = pick_addr();
    src  = pick_addr();
    lq   = 8'($urandom_range(0, 255));
    rh   = pick_hops();
    if (r < 30) begin
      drive_req(REQ_TICK, peer, lq, rh, src);
    end else if (r < 50) begin
      last_peer = peer;
      drive_req(REQ_BEACON, peer, lq, rh, src);
    end else if (r < 70) begin
      drive_req(REQ_UP, peer, lq, rh, src);
    end else if (r < 84) begin
      if ($urandom_range(0, 9) < 4) peer = last_peer;
      drive_req(REQ_DOWN, peer, lq, rh, src);
    end else if (r < 94) begin
      drive_req(REQ_SEND, peer, lq, rh, src);
    end else begin
      drive_req(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic random_phase(input logic [15:0] addr, input logic sink, input logic [15:0] bper,
                              input logic [15:0] tper, input int count);
    settle(64);
    program_node(addr, sink, bper, tper);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = FREE_SLOT;
    addr_pool[2] = addr;
    for (int i = 3; i < 10; i++) addr_pool[i] = 16'($urandom_range(0, 65535));
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) settle(0);
      random_req();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_node(16'h1234, 1'b0, 16'd2, 16'd3);
    drive_req(REQ_UP,     16'h0005, 8'h00, 8'h00, 16'h0100);
    drive_req(REQ_SEND,   16'h0200, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_DOWN,   16'h0000, 8'h00, 8'h00, 16'h1234);
    drive_req(REQ_BEACON, 16'h0010, 8'd100, 8'hff, 16'h0000);
    drive_req(REQ_BEACON, 16'h0010, 8'd50, 8'd3, 16'h0000);
    drive_req(REQ_BEACON, 16'h0010, 8'd200, 8'd7, 16'h0000);
    drive_req(REQ_BEACON, 16'h0020, 8'd10, 8'hfe, 16'h0000);
    drive_req(REQ_BEACON, 16'h0030, 8'd5, 8'h00, 16'h0000);
    drive_req(REQ_BEACON, 16'h0040, 8'h00, 8'd9, 16'h0000);
    drive_req(REQ_UP,     16'h0100, 8'h00, 8'h00, 16'h0100);
    drive_req(REQ_UP,     16'h0100, 8'h00, 8'h00, FREE_SLOT);
    drive_req(REQ_DOWN,   16'h0040, 8'h00, 8'h00, 16'h0100);
    drive_req(REQ_DOWN,   16'h0040, 8'h00, 8'h00, 16'h0200);
    drive_req(REQ_DOWN,   16'h0040, 8'h00, 8'h00, FREE_SLOT);
    drive_req(REQ_BEACON, 16'h0100, 8'h00, 8'h00, 16'h0000);
    repeat (4) drive_req(REQ_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_SEND,   16'hffff, 8'hff, 8'hff, 16'hffff);
    drive_req(REQ_SPARE_FIRST, 16'hffff, 8'hff, 8'hff, 16'hffff);
    drive_req(REQ_SPARE_LAST,  16'h0000, 8'h00, 8'h00, 16'h0000);

    // Gateway with a zero beacon period, so every tick beacons.
    settle(64);
    program_node(16'hffff, 1'b1, 16'd0, 16'd1);
    drive_req(REQ_TICK,   16'h0000, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_BEACON, 16'h0007, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_UP,     16'h0007, 8'h00, 8'h00, 16'habcd);
    drive_req(REQ_SEND,   16'h5555, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_DOWN,   16'h0007, 8'h00, 8'h00, 16'hffff);

    // The parent is kept while the tick count only equals the timeout;
    // after a lower timeout the next tick disconnects the node.
    settle(64);
    program_node(16'h0042, 1'b0, 16'hffff, 16'd30);
    drive_req(REQ_BEACON, 16'h0777, 8'd9, 8'd2, 16'h0000);
    no_gaps = 1'b1;
    repeat (30) drive_req(REQ_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000);
    no_gaps = 1'b0;
    drive_req(REQ_UP,     16'h0000, 8'h00, 8'h00, 16'h0001);
    settle(64);
    write_reg(CFG_TPER, 16'd29);
    cfg_we <= 1'b0;
    drive_req(REQ_TICK,   16'h0000, 8'h00, 8'h00, 16'h0000);
    drive_req(REQ_SEND,   16'h0001, 8'h00, 8'h00, 16'h0000);

    random_phase(16'($urandom_range(0, 65535)), 1'b0, 16'd5, 16'd12, 220);
    random_phase(16'h0000, 1'b0, 16'd1, 16'd1, 150);
    random_phase(16'($urandom_range(0, 65535)), 1'b1, 16'd4, 16'd8, 200);
    random_phase(16'($urandom_range(0, 65535)), 1'b0, 16'hffff, 16'hffff, 200);
    random_phase(16'hffff, 1'b1, 16'd1, 16'd40, 150);
    random_phase(16'($urandom_range(0, 65535)), 1'b0, 16'($urandom_range(1, 30)),
                 16'($urandom_range(2, 40)), 250);
    random_phase(16'($urandom_range(0, 65535)), 1'b1, 16'hffff, 16'd1, 150);
    random_phase(16'($urandom_range(0, 65535)), 1'b0, 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 60)), 300);

    settle(64);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
